### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the rational fraction ALU.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define FA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a second one in the same cycle
`define FA_ASSERT_IMPL(label, cond, conseq, msg) \
	`FA_ASSERT(label, (cond) |-> (conseq), msg)

`endif

### rtl/core/fa_pkg.sv
// Shared types, constants and helpers of the rational fraction ALU.
// Used by the channel interfaces and every module of the block.
`timescale 1ns / 1ps
package fa_pkg;
	localparam int WORD_BITS = 32;
	localparam int KBITS = $clog2(WORD_BITS);

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0] uword_t;

	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t WORD_ONE = word_t'(1);

	// Operation codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Work class chosen by the front end
	typedef enum logic [1:0] {
		K_PASS,
		K_SAME,
		K_MULDIV,
		K_LCM
	} kind_t;

	// One queued item: operand slots depend on the kind
	typedef struct packed {
		kind_t kind;
		logic  sub;
		logic  ovf;
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} ent_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		ent_t ent;
	} deq_t;

	// Magnitude of a signed word, exact for the most negative value
	function automatic uword_t mag(input word_t v);
		mag = v[WORD_BITS-1] ? uword_t'(-v) : uword_t'(v);
	endfunction
endpackage

### rtl/core/fa_req_if.sv
// Request channel of the rational fraction ALU: opcode and two fractions.
// Depends on fa_pkg.
`timescale 1ns / 1ps
interface fa_req_if;
	import fa_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	word_t       a_num;
	word_t       a_den;
	word_t       b_num;
	word_t       b_den;

	modport source(output valid, op, a_num, a_den, b_num, b_den, input ready);
	modport sink(input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

### rtl/core/fa_rsp_if.sv
// Response channel of the rational fraction ALU: result fraction and flags.
// Depends on fa_pkg.
`timescale 1ns / 1ps
interface fa_rsp_if;
	import fa_pkg::*;
	logic  valid;
	logic  ready;
	word_t res_num;
	word_t res_den;
	logic  overflow;
	logic  invalid;

	modport source(output valid, res_num, res_den, overflow, invalid, input ready);
	modport sink(input valid, res_num, res_den, overflow, invalid, output ready);
endinterface

### rtl/core/fa_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle.
// Depends on fa_pkg.
`timescale 1ns / 1ps
module fa_gcd (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fa_pkg::uword_t a,
	input  fa_pkg::uword_t b,
	output logic           done,
	output fa_pkg::uword_t g
);
	import fa_pkg::*;

	logic             run_q;
	uword_t           a_q;
	uword_t           b_q;
	logic [KBITS-1:0] k_q;

	assign done = run_q && (a_q == '0 || b_q == '0);
	assign g    = (a_q | b_q) << k_q;

	// Strip common twos, then odd factors by subtraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
			a_q   <= a;
			b_q   <= b;
			k_q   <= '0;
		end else if (run_q) begin
			if (a_q == '0 || b_q == '0) begin
				run_q <= 1'b0;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end
endmodule

### rtl/core/fa_divu.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on fa_pkg.
`timescale 1ns / 1ps
module fa_divu (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fa_pkg::uword_t n,
	input  fa_pkg::uword_t d,
	output logic           done,
	output fa_pkg::uword_t q
);
	import fa_pkg::*;

	logic             run_q;
	logic             done_q;
	logic [KBITS-1:0] cnt_q;
	uword_t           rem_q;
	uword_t           n_q;
	uword_t           d_q;
	uword_t           q_q;
	logic [WORD_BITS:0] trial;
	logic [WORD_BITS:0] diff;

	assign trial = {rem_q, n_q[WORD_BITS-1]};
	assign diff  = trial - {1'b0, d_q};
	assign done  = done_q;
	assign q     = q_q;

	// Shift in one dividend bit, keep the difference when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == KBITS'(WORD_BITS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= '0;
				n_q   <= n;
				d_q   <= d;
			end else if (run_q) begin
				n_q   <= n_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KBITS'(WORD_BITS - 1)) begin
					run_q <= 1'b0;
				end
				if (!diff[WORD_BITS]) begin
					rem_q <= diff[WORD_BITS-1:0];
					q_q   <= {q_q[WORD_BITS-2:0], 1'b1};
				end else begin
					rem_q <= trial[WORD_BITS-1:0];
					q_q   <= {q_q[WORD_BITS-2:0], 1'b0};
				end
			end
		end
	end
endmodule

### rtl/core/fa_front.sv
// Front end: accepts request items, classifies them, queues two deep.
// Depends on fa_pkg and fa_req_if.
`timescale 1ns / 1ps
module fa_front (
	input  logic         clk,
	input  logic         arst_n,
	fa_req_if.sink       req,
	input  logic         pop,
	output fa_pkg::deq_t deq
);
	import fa_pkg::*;

	ent_t       ent;
	ent_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       sub;
	logic [WORD_BITS:0] sum;

	assign sub = (req.op == OP_SUB);
	assign sum = sub ? ({req.a_num[WORD_BITS-1], req.a_num} - {req.b_num[WORD_BITS-1], req.b_num})
	                 : ({req.a_num[WORD_BITS-1], req.a_num} + {req.b_num[WORD_BITS-1], req.b_num});

	// Classify the item and do the cheap cases here
	always_comb begin
		ent      = '0;
		ent.sub  = sub;
		ent.kind = K_PASS;
		if (req.op == OP_MUL || req.op == OP_DIV) begin
			ent.kind = K_MULDIV;
			ent.w0   = req.a_num;
			ent.w1   = (req.op == OP_MUL) ? req.b_num : req.b_den;
			ent.w2   = req.a_den;
			ent.w3   = (req.op == OP_MUL) ? req.b_den : req.b_num;
		end else if (req.a_num == '0) begin
			ent.w0  = sub ? -req.b_num : req.b_num;
			ent.w1  = req.b_den;
			ent.ovf = sub && (req.b_num == WORD_MIN);
		end else if (req.b_num == '0) begin
			ent.w0 = req.a_num;
			ent.w1 = req.a_den;
		end else if (req.a_den == req.b_den) begin
			ent.kind = K_SAME;
			ent.w0   = sum[WORD_BITS-1:0];
			ent.w1   = req.a_den;
			ent.ovf  = sum[WORD_BITS] != sum[WORD_BITS-1];
		end else if (req.a_den == '0 || req.b_den == '0) begin
			ent.w0 = '0;
			ent.w1 = '0;
		end else begin
			ent.kind = K_LCM;
			ent.w0   = req.a_num;
			ent.w1   = req.a_den;
			ent.w2   = req.b_num;
			ent.w3   = req.b_den;
		end
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign deq.valid = (cnt_q != 2'd0);
	assign deq.ent   = mem_q[rp_q];

	// Hold queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Store queued items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= ent;
		end
	end
endmodule

### rtl/core/fa_back.sv
// Back end: sequencer over a shared multiplier, divider and gcd unit.
// Depends on fa_pkg, fa_rsp_if, fa_gcd and fa_divu.
`timescale 1ns / 1ps
module fa_back (
	input  logic         clk,
	input  logic         arst_n,
	input  fa_pkg::deq_t deq,
	output logic         pop,
	fa_rsp_if.source     rsp
);
	import fa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_MUL1, S_MUL2, S_LGCD, S_LGW, S_LP, S_LDIV, S_M1, S_D1, S_M2,
		S_D2, S_SUM, S_RED, S_RGW, S_RDN, S_RDD, S_RFIX, S_DW, S_DONE
	} state_t;

	state_t state_q;
	state_t ret_q;
	ent_t   e_q;
	word_t  num_q;
	word_t  den_q;
	word_t  l_q;
	word_t  t1_q;
	word_t  dres_q;
	uword_t g_q;
	logic   ovf_q;
	logic   sgn_q;
	logic   out_valid_q;
	word_t  out_num_q;
	word_t  out_den_q;
	logic   out_ovf_q;

	word_t  mx;
	word_t  my;
	logic signed [2*WORD_BITS-1:0] prod;
	word_t  pw;
	logic   povf;
	word_t  dv_n;
	word_t  dv_d;
	logic   dv_go;
	logic   g_go;
	uword_t g_a;
	uword_t g_b;
	logic   g_done;
	uword_t g_res;
	logic   d_done;
	uword_t d_q;
	word_t  dfix;
	logic [WORD_BITS:0] s2;

	// Select multiplier operands by step
	always_comb begin
		mx = '0;
		my = '0;
		case (state_q)
			S_MUL1: begin mx = e_q.w0; my = e_q.w1; end
			S_MUL2: begin mx = e_q.w2; my = e_q.w3; end
			S_LP:   begin mx = e_q.w1; my = e_q.w3; end
			S_M1:   begin mx = e_q.w0; my = dres_q; end
			S_M2:   begin mx = e_q.w2; my = l_q; end
			default: begin mx = '0; my = '0; end
		endcase
	end

	assign prod = mx * my;
	assign pw   = prod[WORD_BITS-1:0];
	assign povf = prod[2*WORD_BITS-1:WORD_BITS-1] != {(WORD_BITS+1){prod[WORD_BITS-1]}};

	// Select divider operands and start it
	always_comb begin
		dv_go = 1'b1;
		dv_n  = '0;
		dv_d  = WORD_ONE;
		case (state_q)
			S_LDIV: begin dv_n = t1_q;   dv_d = word_t'(g_q); end
			S_D1:   begin dv_n = t1_q;   dv_d = e_q.w1; end
			S_D2:   begin dv_n = num_q;  dv_d = e_q.w3; end
			S_RDN:  begin dv_n = num_q;  dv_d = word_t'(g_q); end
			S_RDD:  begin dv_n = den_q;  dv_d = word_t'(g_q); end
			default: dv_go = 1'b0;
		endcase
	end

	// Start gcd on the lcm denominators or on the result
	always_comb begin
		g_go = 1'b0;
		g_a  = mag(e_q.w1);
		g_b  = mag(e_q.w3);
		if (state_q == S_LGCD) begin
			g_go = 1'b1;
		end else if (state_q == S_RED && num_q != '0 && den_q != '0) begin
			g_go = 1'b1;
			g_a  = mag(num_q);
			g_b  = mag(den_q);
		end
	end

	fa_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (g_go),
		.a      (g_a),
		.b      (g_b),
		.done   (g_done),
		.g      (g_res)
	);

	fa_divu u_divu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_go),
		.n      (mag(dv_n)),
		.d      (mag(dv_d)),
		.done   (d_done),
		.q      (d_q)
	);

	assign dfix = sgn_q ? -word_t'(d_q) : word_t'(d_q);
	assign s2   = e_q.sub ? ({t1_q[WORD_BITS-1], t1_q} - {dres_q[WORD_BITS-1], dres_q})
	                      : ({t1_q[WORD_BITS-1], t1_q} + {dres_q[WORD_BITS-1], dres_q});

	assign pop          = (state_q == S_IDLE) && deq.valid;
	assign rsp.valid    = out_valid_q;
	assign rsp.res_num  = out_num_q;
	assign rsp.res_den  = out_den_q;
	assign rsp.overflow = out_ovf_q;
	assign rsp.invalid  = (out_den_q == '0);

	// Sequence one item and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (dv_go) begin
				sgn_q   <= dv_n[WORD_BITS-1] ^ dv_d[WORD_BITS-1];
				state_q <= S_DW;
			end
			case (state_q)
				S_IDLE: begin
					if (deq.valid) begin
						e_q   <= deq.ent;
						num_q <= deq.ent.w0;
						den_q <= deq.ent.w1;
						ovf_q <= deq.ent.ovf;
						case (deq.ent.kind)
							K_PASS:   state_q <= S_DONE;
							K_SAME:   state_q <= S_RED;
							K_MULDIV: state_q <= S_MUL1;
							K_LCM:    state_q <= S_LGCD;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_MUL1: begin
					num_q   <= pw;
					ovf_q   <= ovf_q | povf;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					den_q   <= pw;
					ovf_q   <= ovf_q | povf;
					state_q <= S_RED;
				end
				S_LGCD: state_q <= S_LGW;
				S_LGW: begin
					if (g_done) begin
						g_q     <= g_res;
						state_q <= S_LP;
					end
				end
				S_LP: begin
					t1_q    <= pw;
					ovf_q   <= ovf_q | povf;
					state_q <= S_LDIV;
				end
				S_LDIV: ret_q <= S_M1;
				S_M1: begin
					l_q     <= dres_q;
					t1_q    <= pw;
					ovf_q   <= ovf_q | povf;
					state_q <= S_D1;
				end
				S_D1: ret_q <= S_M2;
				S_M2: begin
					t1_q    <= dres_q;
					num_q   <= pw;
					ovf_q   <= ovf_q | povf;
					state_q <= S_D2;
				end
				S_D2: ret_q <= S_SUM;
				S_SUM: begin
					num_q   <= s2[WORD_BITS-1:0];
					den_q   <= l_q;
					ovf_q   <= ovf_q | (s2[WORD_BITS] != s2[WORD_BITS-1]);
					state_q <= S_RED;
				end
				S_RED: begin
					if (num_q == '0) begin
						den_q   <= WORD_ONE;
						state_q <= S_DONE;
					end else if (den_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RGW;
					end
				end
				S_RGW: begin
					if (g_done) begin
						g_q     <= g_res;
						state_q <= S_RDN;
					end
				end
				S_RDN: ret_q <= S_RDD;
				S_RDD: begin
					num_q <= dres_q;
					ret_q <= S_RFIX;
				end
				S_RFIX: begin
					if (dres_q[WORD_BITS-1]) begin
						num_q <= -num_q;
						den_q <= -dres_q;
						ovf_q <= ovf_q | (num_q == WORD_MIN) | (dres_q == WORD_MIN);
					end else begin
						den_q <= dres_q;
					end
					state_q <= S_DONE;
				end
				S_DW: begin
					if (d_done) begin
						dres_q  <= dfix;
						ovf_q   <= ovf_q | (!sgn_q && d_q[WORD_BITS-1]);
						state_q <= ret_q;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_num_q   <= num_q;
						out_den_q   <= den_q;
						out_ovf_q   <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/rational_fraction_alu.sv
// Channel   | Dir | Payload
// req       | in  | op, a_num, a_den, b_num, b_den
// rsp       | out | res_num, res_den, overflow, invalid
//
// Pass-through items skip the arithmetic; the lcm path takes longest, as
// it runs the divider and the one-step-per-cycle binary gcd most often.
// Two items queue in front while one is worked; req drops ready when full.
// The back end waits on rsp only while the result register is still full.
// arst_n clears queue, sequencer and result valid at once.
// Top level of the rational fraction ALU; depends on fa_pkg, the channel
// interfaces, fa_front, fa_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rational_fraction_alu (
	input  logic     clk,
	input  logic     arst_n,
	fa_req_if.sink   req,
	fa_rsp_if.source rsp
);
	import fa_pkg::*;

	deq_t deq;
	logic pop;

	fa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.deq    (deq)
	);

	fa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.deq    (deq),
		.pop    (pop),
		.rsp    (rsp)
	);

	// Check queue handoff and result flags
	`FA_ASSERT_IMPL(a_pop_valid, pop, deq.valid, "pop from empty queue")
	`FA_ASSERT_IMPL(a_invalid_den, rsp.valid, rsp.invalid == (rsp.res_den == '0), "invalid flag mismatch")
	`FA_ASSERT_IMPL(a_pop_one, pop, ##1 !pop, "two pops in a row")
endmodule
